/* hdl/flashing_output_register_bank_defines.svh */
// ---------------------------------------------------------------------------
// flashing output register bank assertion macros
// Concurrent checks clocked on clk; FORB_ASSERT is held off during reset, FORB_ASSERT_ALWAYS is not.
// ---------------------------------------------------------------------------
`ifndef FLASHING_OUTPUT_REGISTER_BANK_DEFINES_SVH
`define FLASHING_OUTPUT_REGISTER_BANK_DEFINES_SVH

`ifndef SYNTHESIS
`define FORB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FORB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FORB_ASSERT(lbl, prop, msg)
`define FORB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/forb_pkg.sv */
// ---------------------------------------------------------------------------
// forb_pkg
// Types, codes and constants shared by the flashing output register bank.
// ---------------------------------------------------------------------------
`default_nettype none

package forb_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_READ_WORDS   = 4;
	localparam int PIN_W            = 4;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 16;

	localparam logic [15:0] SLOW_HALF_RST = 16'd1200;
	localparam logic [15:0] FAST_HALF_RST = 16'd300;
	localparam logic [15:0] MODE_MAX      = 16'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SLOW_HALF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_HALF = 1'b1;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_ON   = 2'd1;
	localparam logic [1:0] MODE_SLOW = 2'd2;
	localparam logic [1:0] MODE_FAST = 2'd3;

	localparam logic [1:0] OSEL_TICK = 2'd0;
	localparam logic [1:0] OSEL_ERR  = 2'd1;
	localparam logic [1:0] OSEL_DATA = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [15:0] word_count;
		logic [15:0] write_value;
	} forb_req_t;

	typedef struct packed {
		logic             status;
		logic [1:0]       mode_data;
		logic [PIN_W-1:0] pin_levels;
		logic             last;
	} forb_rsp_t;

	typedef struct packed {
		logic       capture;
		logic       do_tick;
		logic       do_write;
		logic       rd_issue;
		logic       next_word;
		logic       load_out;
		logic [1:0] out_sel;
	} forb_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       range_err;
		logic       out_free;
		logic       last_word;
	} forb_sts_t;

	function automatic logic mode_level(input logic [1:0] mode, input logic slow,
			input logic fast);
		logic lvl;
		case (mode)
			MODE_OFF:  lvl = 1'b0;
			MODE_ON:   lvl = 1'b1;
			MODE_SLOW: lvl = slow;
			default:   lvl = fast;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

/* hdl/flashing_output_register_bank.sv */
// ---------------------------------------------------------------------------
// flashing_output_register_bank
// Mode register bank with slow and fast flash phases and a tick pin word.
// ---------------------------------------------------------------------------
// tick and error requests: accept, decode, then one result beat loaded once the result register is free
// read of n words: per word a read issue, the registered ram read, then a beat once the register is free
// write: store (if the value is at most MODE_MAX) then read back for the echoed mode
// one request at a time; result register lets the next request in while a beat waits
// async reset clears counters and per-channel valid bits and sets both phases high; no clearing pass
`default_nettype none

module flashing_output_register_bank
	import forb_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire forb_req_t             req_data,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output forb_rsp_t                  rsp_data
);

	forb_cmd_t cmd;
	forb_sts_t sts;

	forb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	forb_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

/* hdl/forb_ram.sv */
// ---------------------------------------------------------------------------
// forb_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module forb_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/forb_ctrl.sv */
// ---------------------------------------------------------------------------
// forb_ctrl
// Sequencer: takes a request, then steps tick, error or read/echo beats.
// ---------------------------------------------------------------------------
`default_nettype none

`include "flashing_output_register_bank_defines.svh"

module forb_ctrl
	import forb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire forb_sts_t sts,
	output forb_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECODE   = 3'd1;
	localparam logic [2:0] ST_TICK_OUT = 3'd2;
	localparam logic [2:0] ST_ERR_OUT  = 3'd3;
	localparam logic [2:0] ST_RD_REQ   = 3'd4;
	localparam logic [2:0] ST_RD_DATA  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.out_sel = OSEL_TICK;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.func)
					FUNC_TICK: begin
						cmd.do_tick = 1'b1;
						state_d     = ST_TICK_OUT;
					end
					FUNC_READ: begin
						state_d = sts.range_err ? ST_ERR_OUT : ST_RD_REQ;
					end
					FUNC_WRITE: begin
						if (sts.range_err) begin
							state_d = ST_ERR_OUT;
						end else begin
							cmd.do_write = 1'b1;
							state_d      = ST_RD_REQ;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_TICK_OUT: begin
				cmd.out_sel = OSEL_TICK;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ERR_OUT: begin
				cmd.out_sel = OSEL_ERR;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RD_REQ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				cmd.out_sel = OSEL_DATA;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (sts.last_word) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_word = 1'b1;
						state_d       = ST_RD_REQ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FORB_ASSERT(a_load_needs_room, cmd.load_out |-> sts.out_free, "result loaded into full register")
	`FORB_ASSERT(a_accept_decodes, (req_valid && req_ready) |=> (state_q == ST_DECODE), "accept did not decode")
	`FORB_ASSERT(a_issue_then_data, cmd.rd_issue |=> (state_q == ST_RD_DATA), "read issue lost")

endmodule

`default_nettype wire

/* hdl/forb_dp.sv */
// ---------------------------------------------------------------------------
// forb_dp
// Datapath: half period registers, flash counters, mode store, result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "flashing_output_register_bank_defines.svh"

module forb_dp
	import forb_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire forb_req_t             req_data,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output forb_rsp_t                  rsp_data,
	input  wire forb_cmd_t             cmd,
	output forb_sts_t                  sts
);

	localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NLOW = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;

	logic [15:0]      slow_half_q;
	logic [15:0]      fast_half_q;
	logic [15:0]      slow_count_q;
	logic [15:0]      fast_count_q;
	logic             slow_phase_q;
	logic             fast_phase_q;
	forb_req_t        req_q;
	logic [1:0]       word_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [1:0]       low_mode_q [NLOW];
	logic             rd_vld_s1;
	forb_rsp_t        rsp_q;
	logic             rsp_valid_q;

	logic [16:0]      slow_next;
	logic [16:0]      fast_next;
	logic [16:0]      rd_end;
	logic             rd_err;
	logic             wr_err;
	logic             value_ok;
	logic             store;
	logic [AW-1:0]    wr_idx;
	logic [AW-1:0]    rd_idx;
	logic [1:0]       ram_rdata;
	logic [1:0]       rd_mode;
	logic [2:0]       word_p1;
	logic             out_free;
	logic [PIN_W-1:0] pins;
	logic             rd_vld_d;

	assign slow_next = {1'b0, slow_count_q} + 17'd1;
	assign fast_next = {1'b0, fast_count_q} + 17'd1;

	assign rd_end = {1'b0, req_q.addr} + {1'b0, req_q.word_count};
	assign rd_err = (req_q.word_count == 16'd0)
		|| (req_q.word_count > 16'(MAX_READ_WORDS))
		|| (rd_end > 17'(NUM_CHANNELS));
	assign wr_err = req_q.addr >= 16'(NUM_CHANNELS);
	assign value_ok = req_q.write_value <= MODE_MAX;
	assign store    = cmd.do_write && value_ok;

	assign wr_idx  = req_q.addr[AW-1:0];
	assign rd_idx  = AW'(req_q.addr + {14'd0, word_q});
	assign word_p1 = {1'b0, word_q} + 3'd1;
	assign out_free = !rsp_valid_q || rsp_ready;

	assign sts.func      = req_q.func;
	assign sts.range_err = (req_q.func == FUNC_WRITE) ? wr_err : rd_err;
	assign sts.out_free  = out_free;
	assign sts.last_word = (req_q.func == FUNC_WRITE) || (req_q.word_count == {13'd0, word_p1});

	always_comb begin
		rd_vld_d = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (rd_idx == AW'(i)) begin
				rd_vld_d = vld_q[i];
			end
		end
	end

	always_comb begin
		pins = '0;
		for (int i = 0; i < NLOW; i++) begin
			pins[i] = mode_level(low_mode_q[i], slow_phase_q, fast_phase_q);
		end
	end

	assign rd_mode = rd_vld_s1 ? ram_rdata : MODE_OFF;

	forb_ram #(
		.WIDTH (2),
		.DEPTH (NUM_CHANNELS)
	) u_mode_ram (
		.clk   (clk),
		.we    (store),
		.waddr (wr_idx),
		.wdata (req_q.write_value[1:0]),
		.re    (cmd.rd_issue),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_half_q <= SLOW_HALF_RST;
			fast_half_q <= FAST_HALF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOW_HALF: slow_half_q <= cfg_data;
				REG_FAST_HALF: fast_half_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flash counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_count_q <= '0;
			fast_count_q <= '0;
			slow_phase_q <= 1'b1;
			fast_phase_q <= 1'b1;
		end else if (cmd.do_tick) begin
			if (slow_next > {1'b0, slow_half_q}) begin
				slow_count_q <= '0;
				slow_phase_q <= !slow_phase_q;
			end else begin
				slow_count_q <= slow_next[15:0];
			end
			if (fast_next > {1'b0, fast_half_q}) begin
				fast_count_q <= '0;
				fast_phase_q <= !fast_phase_q;
			end else begin
				fast_count_q <= fast_next[15:0];
			end
		end
	end

	// mode valid bits and low channel copies for the pin word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int i = 0; i < NLOW; i++) begin
				low_mode_q[i] <= MODE_OFF;
			end
		end else if (store) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (wr_idx == AW'(i)) begin
					vld_q[i] <= 1'b1;
				end
			end
			for (int i = 0; i < NLOW; i++) begin
				if (req_q.addr == 16'(i)) begin
					low_mode_q[i] <= req_q.write_value[1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.capture) begin
				word_q <= '0;
			end else if (cmd.next_word) begin
				word_q <= word_q + 2'd1;
			end
			if (cmd.rd_issue) begin
				rd_vld_s1 <= rd_vld_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.out_sel)
				OSEL_TICK: rsp_q <= '{status: 1'b0, mode_data: MODE_OFF, pin_levels: pins,
					last: 1'b1};
				OSEL_ERR:  rsp_q <= '{status: 1'b1, mode_data: MODE_OFF, pin_levels: '0,
					last: 1'b1};
				default:   rsp_q <= '{status: 1'b0, mode_data: rd_mode, pin_levels: '0,
					last: sts.last_word};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`FORB_ASSERT(a_load_shows_beat, cmd.load_out |=> rsp_valid, "loaded beat not shown")
	`FORB_ASSERT(a_read_in_range, cmd.rd_issue |-> (req_q.addr + {14'd0, word_q} < 16'(NUM_CHANNELS)), "read beyond bank")
	`FORB_ASSERT(a_write_in_range, store |-> !wr_err, "store outside bank")

endmodule

`default_nettype wire
